// File: hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CountWidth = 5;

	typedef logic signed [ValueWidth-1:0] value_t;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		value_t value;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/spq_if.sv
`default_nettype none

interface spq_req_if import spq_pkg::*;;
	logic   valid;
	logic   ready;
	func_t  func;
	value_t value_in;

	modport source (output valid, output func, output value_in, input ready);
	modport sink (input valid, input func, input value_in, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
	logic                  valid;
	logic                  ready;
	value_t                value_out;
	status_t               status;
	logic [CountWidth-1:0] entry_count;
	logic                  is_empty;

	modport source (output valid, output value_out, output status, output entry_count,
		output is_empty, input ready);
	modport sink (input valid, input value_out, input status, input entry_count,
		input is_empty, output ready);
endinterface

`default_nettype wire

// File: hdl/spq_cell.sv
`default_nettype none

module spq_cell import spq_pkg::*; (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occupied,
	input  wire logic      at_tail,
	input  wire value_t    left_value,
	input  wire logic      left_le,
	input  wire value_t    right_value,
	output value_t         value,
	output logic           le
);

	value_t value_q;

	assign value = value_q;
	assign le    = occupied && (value_q <= ctl.value);

	// The chain stays sorted, so the first cell whose entry is not above the new
	// value takes it and every cell after it takes its left neighbor's entry.
	always_ff @(posedge clk) begin
		priority if (ctl.push) begin
			priority if (left_le) begin
				value_q <= left_value;
			end else if (le || at_tail) begin
				value_q <= ctl.value;
			end else begin
				value_q <= value_q;
			end
		end else if (ctl.pop) begin
			value_q <= right_value;
		end else begin
			value_q <= value_q;
		end
	end

endmodule

`default_nettype wire

// File: hdl/sorted_priority_queue.sv
// Channel | Dir | Payload                                    | Request
// req     | in  | func, value_in                             | push value or pop head
// rsp     | out | value_out, status, entry_count, is_empty   | one result per request
//
// For each request, the whole cell chain compares and shifts in the cycle
// the request is accepted, and the result lands in the output register.
// A new request is accepted while the output register is empty or being drained.
// arst_n clears the entry count and the output valid; cell contents need no reset.
// A stalled result holds its output register and blocks further requests.

`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input wire logic   clk,
	input wire logic   arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_next;
	logic            rsp_valid_q;
	value_t          value_out_q;
	status_t         status_q;
	logic [CntW-1:0] count_out_q;

	logic      accept;
	logic      full;
	logic      empty;
	logic      do_push;
	logic      do_pop;
	cell_ctl_t ctl;

	value_t cell_value [DEPTH];
	logic   cell_le    [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CntW'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = accept && (req.func == FUNC_PUSH) && !full;
	assign do_pop    = accept && (req.func == FUNC_POP) && !empty;

	assign ctl.push  = do_push;
	assign ctl.pop   = do_pop;
	assign ctl.value = req.value_in;

	always_comb begin
		priority if (do_push) begin
			count_next = count_q + 1'b1;
		end else if (do_pop) begin
			count_next = count_q - 1'b1;
		end else begin
			count_next = count_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		value_t left_value;
		logic   left_le;
		value_t right_value;

		if (i == 0) begin : g_head
			assign left_value = req.value_in;
			assign left_le    = 1'b0;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign left_le    = cell_le[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_value = cell_value[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (count_q > CntW'(i)),
			.at_tail     (count_q == CntW'(i)),
			.left_value  (left_value),
			.left_le     (left_le),
			.right_value (right_value),
			.value       (cell_value[i]),
			.le          (cell_le[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= do_pop ? cell_value[0] : '0;
			count_out_q <= count_next;
			unique case (req.func)
				FUNC_PUSH: status_q <= full ? STATUS_FULL : STATUS_OK;
				FUNC_POP:  status_q <= empty ? STATUS_EMPTY : STATUS_OK;
				default:   status_q <= STATUS_OK;
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.value_out   = value_out_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = CountWidth'(count_out_q);
	assign rsp.is_empty    = (count_out_q == '0);

endmodule

`default_nettype wire
